// File: design/hbwd_pkg.sv
// shared types, constants and helpers of the heartbeat watchdog
`default_nettype none
package hbwd_pkg;

  // counter and register widths
  localparam int COUNT_WIDTH = 16;
  localparam int CFG_WIDTH   = 16;
  localparam int CMP_WIDTH   = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;
  localparam int IDX_WIDTH   = 8;
  localparam int IN_BITS     = 8;
  localparam int OUT_BITS    = 8;

  // register indexes
  localparam logic [IDX_WIDTH-1:0] REG_WINDOW    = IDX_WIDTH'(0);
  localparam logic [IDX_WIDTH-1:0] REG_POWER_OFF = IDX_WIDTH'(1);
  localparam logic [IDX_WIDTH-1:0] REG_POWER_ON  = IDX_WIDTH'(2);
  localparam logic [IDX_WIDTH-1:0] REG_BAUD_WAIT = IDX_WIDTH'(3);

  // register reset values
  localparam logic [CFG_WIDTH-1:0] WINDOW_RST    = CFG_WIDTH'(2500);
  localparam logic [CFG_WIDTH-1:0] POWER_OFF_RST = CFG_WIDTH'(100);
  localparam logic [CFG_WIDTH-1:0] POWER_ON_RST  = CFG_WIDTH'(500);
  localparam logic [CFG_WIDTH-1:0] BAUD_WAIT_RST = CFG_WIDTH'(1400);

  // uart action codes
  typedef enum logic [2:0] {
    ACT_NONE = 3'd0,
    ACT_INIT = 3'd1,
    ACT_BAUD = 3'd2,
    ACT_9600 = 3'd3,
    ACT_OPEN = 3'd4
  } uart_action_t;

  // recovery sequence steps
  typedef enum logic [2:0] {
    STEP_OFF       = 3'd0,
    STEP_OFF_WAIT  = 3'd1,
    STEP_ON        = 3'd2,
    STEP_ON_WAIT   = 3'd3,
    STEP_BAUD      = 3'd4,
    STEP_BAUD_WAIT = 3'd5,
    STEP_OPEN      = 3'd6,
    STEP_IDLE      = 3'd7
  } seq_step_t;

  // configuration register set
  typedef struct packed {
    logic [CFG_WIDTH-1:0] window_ticks;
    logic [CFG_WIDTH-1:0] power_off_ticks;
    logic [CFG_WIDTH-1:0] power_on_wait_ticks;
    logic [CFG_WIDTH-1:0] baud_wait_ticks;
  } cfg_t;

  // one result item, power_enable in the lowest bit
  typedef struct packed {
    logic         recovering;
    uart_action_t uart_action;
    logic         power_enable;
  } result_t;

  // true when a counter value is strictly above a limit
  function automatic logic exceeds(input logic [COUNT_WIDTH-1:0] count,
                                   input logic [CFG_WIDTH-1:0] limit);
    logic [CMP_WIDTH-1:0] count_ext;
    logic [CMP_WIDTH-1:0] limit_ext;
    count_ext = CMP_WIDTH'(count);
    limit_ext = CMP_WIDTH'(limit);
    return count_ext > limit_ext;
  endfunction

endpackage
`default_nettype wire

// File: design/heartbeat_watchdog_power_cycle.sv
// Heartbeat watchdog with power-cycle recovery of a supervised device.
// Each transfer on the s_ channel is one timer tick carrying a heartbeat
// pulse and a system-closed level. Each tick yields exactly one transfer on
// the m_ channel: the power enable level, a uart action code and the
// recovery flag, in tick order.
// The cfg channel writes the four timing registers by index; it is always
// ready, and writes to an index past the list are dropped. Write it only
// while no tick is in flight.
// A tick accepted into the input register is computed by hbwd_core into the
// output register when it advances, and its result is then offered on m_.
// Throughput: one tick per cycle while m_tready takes each result, set by the
// state update in hbwd_core between the input register and the output register.
// When m_tready is low the result holds in the output register; one more
// tick waits in the input register, and s_tready drops only when both are
// full. Reset clears both stages, reloads the register defaults, clears the
// counters, the heartbeat latch and the recovery state, and turns power on.
`default_nettype none
module heartbeat_watchdog_power_cycle (
  input  logic                              clk,
  input  logic                              rst,
  // tick input: [0] heartbeat, [1] system_closed
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [hbwd_pkg::IN_BITS-1:0]      s_tdata,
  // result: [0] power_enable, [3:1] uart_action, [4] recovering
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [hbwd_pkg::OUT_BITS-1:0]     m_tdata,
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hbwd_pkg::IDX_WIDTH-1:0]    cfg_index,
  input  logic [hbwd_pkg::CFG_WIDTH-1:0]    cfg_data
);
  import hbwd_pkg::*;

  cfg_t    cfg;
  logic    in_valid;
  logic    in_heartbeat;
  logic    in_closed;
  logic    out_valid;
  result_t out_result;
  result_t core_result;
  logic    advance;
  logic    in_take;

  assign cfg_ready = 1'b1;

  // timing registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_ticks        <= WINDOW_RST;
      cfg.power_off_ticks     <= POWER_OFF_RST;
      cfg.power_on_wait_ticks <= POWER_ON_RST;
      cfg.baud_wait_ticks     <= BAUD_WAIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WINDOW:    cfg.window_ticks        <= cfg_data;
        REG_POWER_OFF: cfg.power_off_ticks     <= cfg_data;
        REG_POWER_ON:  cfg.power_on_wait_ticks <= cfg_data;
        REG_BAUD_WAIT: cfg.baud_wait_ticks     <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline flow control
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign in_take  = s_tvalid && s_tready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_heartbeat <= s_tdata[0];
      in_closed    <= s_tdata[1];
    end
  end

  hbwd_core u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .step          (advance),
    .heartbeat     (in_heartbeat),
    .system_closed (in_closed),
    .result        (core_result)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= core_result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_BITS'(out_result);

  // a uart action is only issued while recovering
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_result.uart_action != ACT_NONE) |-> out_result.recovering)
    else $error("uart action outside recovery");

  // uart init always goes out together with power off
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_result.uart_action == ACT_INIT) |-> !out_result.power_enable)
    else $error("uart init with power on");

  // the action code stays within the defined set
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_result.uart_action == ACT_NONE || out_result.uart_action == ACT_INIT ||
                   out_result.uart_action == ACT_BAUD || out_result.uart_action == ACT_9600 ||
                   out_result.uart_action == ACT_OPEN))
    else $error("undefined uart action code");

  // a result not taken stays in the output register and nothing advances
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_tready |=> out_valid && $stable(out_result))
    else $error("stalled result changed");

endmodule
`default_nettype wire

// File: design/hbwd_core.sv
// window judging and power-cycle recovery sequencer, one tick per step
`default_nettype none
module hbwd_core (
  input  logic             clk,
  input  logic             rst,
  input  hbwd_pkg::cfg_t   cfg,
  input  logic             step,
  input  logic             heartbeat,
  input  logic             system_closed,
  output hbwd_pkg::result_t result
);
  import hbwd_pkg::*;

  logic [COUNT_WIDTH-1:0] window_count;
  logic [COUNT_WIDTH-1:0] window_count_next;
  logic                   heartbeat_latch;
  logic                   heartbeat_latch_next;
  logic                   recovery_active;
  logic                   recovery_active_next;
  seq_step_t              sequence_step;
  seq_step_t              sequence_step_next;
  logic [COUNT_WIDTH-1:0] delay_count;
  logic [COUNT_WIDTH-1:0] delay_count_next;
  logic                   power_level;
  logic                   power_level_next;

  logic                   latch_set;
  logic [COUNT_WIDTH-1:0] window_inc;
  logic                   window_end;
  logic [COUNT_WIDTH-1:0] delay_inc;
  seq_step_t              step_start;
  uart_action_t           action;

  // state registers, advanced once per tick
  always_ff @(posedge clk) begin
    if (rst) begin
      window_count    <= '0;
      heartbeat_latch <= 1'b0;
      recovery_active <= 1'b0;
      sequence_step   <= STEP_OFF;
      delay_count     <= '0;
      power_level     <= 1'b1;
    end else if (step) begin
      window_count    <= window_count_next;
      heartbeat_latch <= heartbeat_latch_next;
      recovery_active <= recovery_active_next;
      sequence_step   <= sequence_step_next;
      delay_count     <= delay_count_next;
      power_level     <= power_level_next;
    end
  end

  // window judging, then one sequencer step
  always_comb begin
    latch_set  = heartbeat_latch | heartbeat;
    window_inc = window_count + 1'b1;
    window_end = exceeds(window_inc, cfg.window_ticks);
    delay_inc  = delay_count + 1'b1;

    window_count_next    = window_end ? '0 : window_inc;
    heartbeat_latch_next = window_end ? 1'b0 : latch_set;
    recovery_active_next = recovery_active;
    step_start           = sequence_step;

    // failed window restarts recovery from the top
    if (window_end) begin
      if (latch_set | system_closed) begin
        recovery_active_next = 1'b0;
      end else begin
        recovery_active_next = 1'b1;
        step_start           = STEP_OFF;
      end
    end

    sequence_step_next = step_start;
    delay_count_next   = delay_count;
    power_level_next   = power_level;
    action             = ACT_NONE;

    if (recovery_active_next) begin
      case (step_start)
        STEP_OFF: begin
          power_level_next   = 1'b0;
          delay_count_next   = '0;
          action             = ACT_INIT;
          sequence_step_next = STEP_OFF_WAIT;
        end
        STEP_OFF_WAIT: begin
          delay_count_next = delay_inc;
          if (exceeds(delay_inc, cfg.power_off_ticks)) begin
            sequence_step_next = STEP_ON;
          end
        end
        STEP_ON: begin
          power_level_next   = 1'b1;
          delay_count_next   = '0;
          sequence_step_next = STEP_ON_WAIT;
        end
        STEP_ON_WAIT: begin
          delay_count_next = delay_inc;
          if (exceeds(delay_inc, cfg.power_on_wait_ticks)) begin
            sequence_step_next = STEP_BAUD;
          end
        end
        STEP_BAUD: begin
          action             = ACT_BAUD;
          delay_count_next   = '0;
          sequence_step_next = STEP_BAUD_WAIT;
        end
        STEP_BAUD_WAIT: begin
          delay_count_next = delay_inc;
          if (exceeds(delay_inc, cfg.baud_wait_ticks)) begin
            action             = ACT_9600;
            sequence_step_next = STEP_OPEN;
          end
        end
        STEP_OPEN: begin
          action             = ACT_OPEN;
          sequence_step_next = STEP_IDLE;
        end
        default: begin
          action = ACT_NONE;
        end
      endcase
    end

    result.power_enable = power_level_next;
    result.uart_action  = action;
    result.recovering   = recovery_active_next;
  end

endmodule
`default_nettype wire
